### hdl/spatial_key_fifo_cache_core_assert.svh
// assertion macros for the cache core
`ifndef SPATIAL_KEY_FIFO_CACHE_CORE_ASSERT_SVH
`define SPATIAL_KEY_FIFO_CACHE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SKC_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SKC_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SKC_ASSERT_IMPL(label, clk, rst, prop, msg)
`define SKC_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

### hdl/skc_pkg.sv
`default_nettype none
package skc_pkg;
   localparam int ENTRIES_DEF      = 64;
   localparam int PAYLOAD_BITS_DEF = 32;
   localparam int CAP_W            = 7;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [2:0] {
      CMD_FIND   = 3'd0,
      CMD_PUB    = 3'd1,
      CMD_POINT  = 3'd2,
      CMD_COLUMN = 3'd3,
      CMD_EPOCH  = 3'd4
   } cmd_type;

   // scan kinds for the datapath
   typedef enum logic [2:0] {
      SCAN_MATCH  = 3'd0,
      SCAN_OLDEST = 3'd1,
      SCAN_FREE   = 3'd2,
      SCAN_COLUMN = 3'd3,
      SCAN_CLEAR  = 3'd4
   } scan_type;

   typedef struct packed {
      logic       load;       // latch request beat
      logic       scan_start;
      scan_type   scan_kind;
      logic [1:0] key_level;  // level used for match scan
      logic       use_point;  // match uses floor-shifted point key
      logic       drop_hit;   // drop the match hit
      logic       drop_old;   // drop the oldest entry
      logic       write_new;  // write new entry at free slot
      logic       write_upd;  // update payload/epoch at hit
      logic       tick;       // raise ticket
      logic       set_epoch;
      logic       clear_cnt;
      logic       set_result;
      logic       res_ok;
      logic       res_found;
   } ctl_type;

   typedef struct packed {
      logic     scan_done;
      logic     hit;
      logic     any_valid;
      logic     free_found;
      logic     ticket_ok;
      logic     epoch_diff;
      logic     cap_zero;
      logic     full;
      cmd_type  cmd;
      logic [1:0] level;
   } sts_type;

   function automatic logic [31:0] floor_shift(input logic [31:0] v, input logic [1:0] l);
      logic [31:0] r;
      case (l)
         2'd0:    r = 32'($signed(v) >>> 2);
         2'd1:    r = 32'($signed(v) >>> 4);
         default: r = 32'($signed(v) >>> 6);
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

### hdl/skc_datapath.sv
`default_nettype none
module skc_datapath #(
   parameter int ENTRIES      = skc_pkg::ENTRIES_DEF,
   parameter int PAYLOAD_BITS = skc_pkg::PAYLOAD_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire skc_pkg::ctl_type  ctl,
   output skc_pkg::sts_type       sts,
   input  wire logic [2:0]        in_cmd,
   input  wire logic [31:0]       in_x,
   input  wire logic [31:0]       in_y,
   input  wire logic [31:0]       in_z,
   input  wire logic [1:0]        in_level,
   input  wire logic [31:0]       in_payload,
   input  wire logic [63:0]       in_ticket,
   input  wire logic [63:0]       in_epoch,
   input  wire logic [skc_pkg::CAP_W-1:0] capacity,
   output logic [PAYLOAD_BITS-1:0] res_payload,
   output logic [63:0]            res_epoch,
   output logic [63:0]            res_ticket,
   output logic                   res_ok
);
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   logic [31:0] kx_mem [ENTRIES];
   logic [31:0] ky_mem [ENTRIES];
   logic [31:0] kz_mem [ENTRIES];
   logic [1:0]  kl_mem [ENTRIES];
   logic [PAYLOAD_BITS-1:0] pay_mem [ENTRIES];
   logic [63:0] ep_mem [ENTRIES];
   logic [63:0] st_mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;

   logic [2:0]  cmd_ff;
   logic [31:0] x_ff, y_ff, z_ff;
   logic [1:0]  lvl_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;
   logic [63:0] tk_ff, wep_ff;
   logic [63:0] ticket_ff, ticket_in, epoch_ff, ins_ff;
   logic [CW-1:0] used_ff, used_in;

   logic          busy_ff;
   logic [CW-1:0] idx_ff;  // one past last issued index
   logic          rd_vld_ff;
   logic [IW-1:0] rd_idx_ff;
   skc_pkg::scan_type kind_ff;
   logic [1:0]    slvl_ff;
   logic          spt_ff;
   logic          hit_ff, old_ff, free_ff;
   logic [IW-1:0] hit_idx_ff, old_idx_ff, free_idx_ff;
   logic [63:0]   best_age_ff;
   logic          done_ff;

   logic [31:0] r_x, r_y, r_z;
   logic [1:0]  r_l;
   logic [63:0] r_st;
   logic        r_v;
   logic [31:0] kx, ky, kz;
   logic        is_match, is_col;
   logic [63:0] age;
   logic signed [39:0] cx, cz, nx, nz, w;

   // registered read of one entry a cycle
   always_ff @(posedge clock) begin
      r_x  <= kx_mem[rd_idx_ff];
      r_y  <= ky_mem[rd_idx_ff];
      r_z  <= kz_mem[rd_idx_ff];
      r_l  <= kl_mem[rd_idx_ff];
      r_st <= st_mem[rd_idx_ff];
   end
   logic [IW-1:0] cmp_idx_ff;
   logic          cmp_vld_ff;
   assign r_v = valid_ff[cmp_idx_ff];

   always_comb begin
      if (spt_ff) begin
         kx = skc_pkg::floor_shift(x_ff, slvl_ff);
         ky = skc_pkg::floor_shift(y_ff, slvl_ff);
         kz = skc_pkg::floor_shift(z_ff, slvl_ff);
      end else begin
         kx = x_ff;
         ky = y_ff;
         kz = z_ff;
      end
      is_match = r_v && r_x == kx && r_y == ky && r_z == kz && r_l == slvl_ff;
      age = ins_ff - r_st;
      case (r_l)
         2'd0:    w = 40'sd4;
         2'd1:    w = 40'sd16;
         2'd2:    w = 40'sd64;
         default: w = 40'sd256;
      endcase
      cx = 40'($signed(x_ff)) <<< 5;
      cz = 40'($signed(z_ff)) <<< 5;
      case (r_l)
         2'd0:    begin nx = 40'($signed(r_x)) <<< 2; nz = 40'($signed(r_z)) <<< 2; end
         2'd1:    begin nx = 40'($signed(r_x)) <<< 4; nz = 40'($signed(r_z)) <<< 4; end
         2'd2:    begin nx = 40'($signed(r_x)) <<< 6; nz = 40'($signed(r_z)) <<< 6; end
         default: begin nx = 40'($signed(r_x)) <<< 8; nz = 40'($signed(r_z)) <<< 8; end
      endcase
      is_col = r_v && (nx < cx + 40'sd32) && (nx + w > cx) && (nz < cz + 40'sd32) &&
               (nz + w > cz);
   end

   logic [CW-1:0] cap_eff;
   assign cap_eff = (int'(capacity) > ENTRIES) ? CW'(ENTRIES) : CW'(capacity);

   always_comb begin
      valid_in = valid_ff;
      used_in  = used_ff;
      ticket_in = ticket_ff;
      if (cmp_vld_ff && kind_ff == skc_pkg::SCAN_COLUMN && is_col) begin
         valid_in[cmp_idx_ff] = 1'b0;
         used_in = used_ff - CW'(1);
      end
      if (ctl.drop_hit && hit_ff) begin
         valid_in[hit_idx_ff] = 1'b0;
         used_in = used_ff - CW'(1);
      end
      if (ctl.drop_old && old_ff) begin
         valid_in[old_idx_ff] = 1'b0;
         used_in = used_ff - CW'(1);
      end
      if (ctl.write_new) begin
         valid_in[free_idx_ff] = 1'b1;
         used_in = used_ff + CW'(1);
      end
      if (ctl.clear_cnt) begin
         valid_in = '0;
         used_in  = '0;
      end
      if (ctl.tick) ticket_in = ticket_ff + 64'd1;
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= in_cmd;
         x_ff   <= in_x;
         y_ff   <= in_y;
         z_ff   <= in_z;
         lvl_ff <= in_level;
         pay_ff <= PAYLOAD_BITS'(in_payload);
         tk_ff  <= in_ticket;
         wep_ff <= in_epoch;
      end
      if (ctl.write_new) begin
         kx_mem[free_idx_ff] <= x_ff;
         ky_mem[free_idx_ff] <= y_ff;
         kz_mem[free_idx_ff] <= z_ff;
         kl_mem[free_idx_ff] <= lvl_ff;
         st_mem[free_idx_ff] <= ins_ff;
         pay_mem[free_idx_ff] <= pay_ff;
         ep_mem[free_idx_ff]  <= ticket_ff;
      end
      if (ctl.write_upd) begin
         pay_mem[hit_idx_ff] <= pay_ff;
         ep_mem[hit_idx_ff]  <= ticket_ff;
      end
      if (ctl.set_result) begin
         res_ok      <= ctl.res_ok;
         res_ticket  <= ticket_ff;
         res_payload <= ctl.res_found ? pay_mem[hit_idx_ff] : '0;
         res_epoch   <= ctl.res_found ? ep_mem[hit_idx_ff] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         used_ff   <= '0;
         ticket_ff <= '0;
         epoch_ff  <= '0;
         ins_ff    <= '0;
         busy_ff   <= 1'b0;
         rd_vld_ff <= 1'b0;
         cmp_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
         idx_ff    <= '0;
         rd_idx_ff <= '0;
         cmp_idx_ff <= '0;
         kind_ff   <= skc_pkg::SCAN_MATCH;
         slvl_ff   <= '0;
         spt_ff    <= 1'b0;
         hit_ff    <= 1'b0;
         old_ff    <= 1'b0;
         free_ff   <= 1'b0;
         hit_idx_ff <= '0;
         old_idx_ff <= '0;
         free_idx_ff <= '0;
         best_age_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         used_ff   <= used_in;
         ticket_ff <= ticket_in;
         if (ctl.set_epoch) epoch_ff <= wep_ff;
         if (ctl.write_new) ins_ff <= ins_ff + 64'd1;
         // issue stage
         if (ctl.scan_start) begin
            busy_ff <= 1'b1;
            rd_vld_ff <= 1'b0;
            idx_ff  <= '0;
            kind_ff <= ctl.scan_kind;
            slvl_ff <= ctl.key_level;
            spt_ff  <= ctl.use_point;
            hit_ff  <= 1'b0;
            old_ff  <= 1'b0;
            free_ff <= 1'b0;
         end else if (busy_ff) begin
            if (idx_ff == CW'(ENTRIES)) begin
               busy_ff <= 1'b0;
               rd_vld_ff <= 1'b0;
            end else begin
               rd_vld_ff <= 1'b1;
               rd_idx_ff <= IW'(idx_ff);
               idx_ff    <= idx_ff + CW'(1);
            end
         end else begin
            rd_vld_ff <= 1'b0;
         end
         // compare stage, aligned with registered read data
         cmp_vld_ff <= rd_vld_ff;
         cmp_idx_ff <= rd_idx_ff;
         if (cmp_vld_ff) begin
            case (kind_ff)
               skc_pkg::SCAN_MATCH: begin
                  if (is_match && !hit_ff) begin
                     hit_ff <= 1'b1;
                     hit_idx_ff <= cmp_idx_ff;
                  end
               end
               skc_pkg::SCAN_OLDEST: begin
                  if (r_v && (!old_ff || age > best_age_ff)) begin
                     old_ff <= 1'b1;
                     old_idx_ff <= cmp_idx_ff;
                     best_age_ff <= age;
                  end
               end
               skc_pkg::SCAN_FREE: begin
                  if (!r_v && !free_ff) begin
                     free_ff <= 1'b1;
                     free_idx_ff <= cmp_idx_ff;
                  end
               end
               default: ;
            endcase
         end
         done_ff <= !busy_ff && !rd_vld_ff && cmp_vld_ff;
      end
   end

   always_comb begin
      sts.scan_done  = done_ff;
      sts.hit        = hit_ff;
      sts.any_valid  = old_ff;
      sts.free_found = free_ff;
      sts.ticket_ok  = tk_ff == ticket_ff;
      sts.epoch_diff = wep_ff != epoch_ff;
      sts.cap_zero   = cap_eff == '0;
      sts.full       = used_ff >= cap_eff;
      sts.cmd        = skc_pkg::cmd_type'(cmd_ff);
      sts.level      = lvl_ff;
   end

   `include "spatial_key_fifo_cache_core_assert.svh"
   `SKC_ASSERT_IMPL(a_used_bound, clock, reset, used_ff <= CW'(ENTRIES), "used count overflow")
   `SKC_ASSERT_IMPL(a_count_match, clock, reset, $countones(valid_ff) == int'(used_ff), "count off")
   `SKC_ASSERT_IMPL(a_new_free, clock, reset, ctl.write_new |-> !valid_ff[free_idx_ff], "insert over a live entry")
endmodule
`default_nettype wire

### hdl/skc_ctrl.sv
`default_nettype none
module skc_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire skc_pkg::sts_type sts,
   output skc_pkg::ctl_type      ctl
);
   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_FIND, S_PUB_MATCH, S_PUB_OLD, S_PUB_DROP, S_PUB_FREE,
      S_PUB_WRITE, S_PT_SCAN, S_PT_DROP, S_COL, S_RESULT, S_WAIT
   } state_type;

   state_type state_ff;
   logic [1:0] plvl_ff;
   logic rsp_valid_ff;
   logic pend_ok_ff, pend_found_ff;
   skc_pkg::ctl_type ctl_ff;

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;

   // request fields are latched at the accepting edge itself
   always_comb begin
      ctl = ctl_ff;
      ctl.load = req_tvalid && req_tready;
   end

   always_ff @(posedge clock) begin : p_fsm
      skc_pkg::ctl_type ctl_in;
      logic pub_reject;
      if (reset) begin
         state_ff <= S_IDLE;
         plvl_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ok_ff <= 1'b0;
         pend_found_ff <= 1'b0;
         ctl_ff <= '0;
      end else begin
         ctl_in = '0;
         pub_reject = !sts.ticket_ok || sts.cap_zero || sts.level == 2'd3;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) state_ff <= S_DISPATCH;
            end
            S_DISPATCH: begin
               pend_ok_ff <= !(sts.cmd == skc_pkg::CMD_PUB && pub_reject);
               pend_found_ff <= 1'b0;
               case (sts.cmd)
                  skc_pkg::CMD_FIND: begin
                     ctl_in.scan_start = 1'b1;
                     ctl_in.scan_kind = skc_pkg::SCAN_MATCH;
                     ctl_in.key_level = sts.level;
                     state_ff <= S_FIND;
                  end
                  skc_pkg::CMD_PUB: begin
                     if (pub_reject) begin
                        state_ff <= S_RESULT;
                     end else begin
                        ctl_in.scan_start = 1'b1;
                        ctl_in.scan_kind = skc_pkg::SCAN_MATCH;
                        ctl_in.key_level = sts.level;
                        state_ff <= S_PUB_MATCH;
                     end
                  end
                  skc_pkg::CMD_POINT: begin
                     ctl_in.tick = 1'b1;
                     ctl_in.scan_start = 1'b1;
                     ctl_in.scan_kind = skc_pkg::SCAN_MATCH;
                     ctl_in.key_level = 2'd0;
                     ctl_in.use_point = 1'b1;
                     plvl_ff <= 2'd0;
                     state_ff <= S_PT_SCAN;
                  end
                  skc_pkg::CMD_COLUMN: begin
                     ctl_in.tick = 1'b1;
                     ctl_in.scan_start = 1'b1;
                     ctl_in.scan_kind = skc_pkg::SCAN_COLUMN;
                     state_ff <= S_COL;
                  end
                  skc_pkg::CMD_EPOCH: begin
                     if (sts.epoch_diff) begin
                        ctl_in.tick = 1'b1;
                        ctl_in.set_epoch = 1'b1;
                        ctl_in.clear_cnt = 1'b1;
                     end
                     state_ff <= S_RESULT;
                  end
                  default: state_ff <= S_RESULT;
               endcase
            end
            S_FIND: begin
               if (sts.scan_done) begin
                  pend_ok_ff <= sts.hit;
                  pend_found_ff <= sts.hit;
                  state_ff <= S_RESULT;
               end
            end
            S_PUB_MATCH: begin
               if (sts.scan_done) begin
                  if (sts.hit) begin
                     ctl_in.write_upd = 1'b1;
                     state_ff <= S_RESULT;
                  end else if (sts.full) begin
                     ctl_in.scan_start = 1'b1;
                     ctl_in.scan_kind = skc_pkg::SCAN_OLDEST;
                     state_ff <= S_PUB_OLD;
                  end else begin
                     ctl_in.scan_start = 1'b1;
                     ctl_in.scan_kind = skc_pkg::SCAN_FREE;
                     state_ff <= S_PUB_FREE;
                  end
               end
            end
            S_PUB_OLD: begin
               if (sts.scan_done) begin
                  ctl_in.drop_old = 1'b1;
                  state_ff <= S_PUB_DROP;
               end
            end
            S_PUB_DROP: begin
               ctl_in.scan_start = 1'b1;
               ctl_in.scan_kind = skc_pkg::SCAN_FREE;
               state_ff <= S_PUB_FREE;
            end
            S_PUB_FREE: begin
               if (sts.scan_done) begin
                  if (sts.free_found) ctl_in.write_new = 1'b1;
                  else pend_ok_ff <= 1'b0;
                  state_ff <= S_PUB_WRITE;
               end
            end
            S_PUB_WRITE: state_ff <= S_RESULT;
            S_PT_SCAN: begin
               if (sts.scan_done) begin
                  ctl_in.drop_hit = 1'b1;
                  state_ff <= S_PT_DROP;
               end
            end
            S_PT_DROP: begin
               if (plvl_ff == 2'd2) begin
                  state_ff <= S_RESULT;
               end else begin
                  ctl_in.scan_start = 1'b1;
                  ctl_in.scan_kind = skc_pkg::SCAN_MATCH;
                  ctl_in.key_level = plvl_ff + 2'd1;
                  ctl_in.use_point = 1'b1;
                  plvl_ff <= plvl_ff + 2'd1;
                  state_ff <= S_PT_SCAN;
               end
            end
            S_COL: if (sts.scan_done) state_ff <= S_RESULT;
            S_RESULT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  ctl_in.set_result = 1'b1;
                  ctl_in.res_ok = pend_ok_ff;
                  ctl_in.res_found = pend_found_ff;
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         ctl_ff <= ctl_in;
      end
   end

   `include "spatial_key_fifo_cache_core_assert.svh"
   `SKC_ASSERT_IMPL(a_one_req, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "request taken while busy")
   `SKC_ASSERT_IMPL(a_res_slot, clock, reset, ctl.set_result |-> (!rsp_valid_ff || $past(rsp_tready)), "result overwritten")
   `SKC_ASSERT_IMPL(a_drop_excl, clock, reset, !(ctl.write_new && ctl.drop_old), "insert and evict together")
endmodule
`default_nettype wire

### hdl/spatial_key_fifo_cache_core.sv
`default_nettype none
// Fully associative spatial node cache. Commands are taken one at a time: req_tready is high
// only while the block is idle, and find, publish, point and column commands scan the table
// through one registered read port, one entry a cycle. A find, a column invalidate or a
// publish that overwrites runs one scan, a point invalidate three match scans, a publish that
// inserts a match and a free-slot scan, with an oldest-entry scan between them when the table
// is full and the oldest entry is evicted first; an epoch reset, a rejected publish or an
// unknown command runs no scan. The next beat is taken from the cycle rsp_tvalid rises; a
// result not yet taken holds the next command in its final state until the response
// register is free.
module spatial_key_fifo_cache_core #(
   parameter int ENTRIES      = skc_pkg::ENTRIES_DEF,
   parameter int PAYLOAD_BITS = skc_pkg::PAYLOAD_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // command[2:0], coord_x, coord_y, coord_z, level[1:0], payload, ticket, new epoch
   input  wire logic [263:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // ok, found_payload, found_epoch, current_ticket
   output logic [167:0]      rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [skc_pkg::CAP_W-1:0] csr_wdata
);
   logic [skc_pkg::CAP_W-1:0] cap_ff;
   skc_pkg::ctl_type ctl;
   skc_pkg::sts_type sts;
   logic [PAYLOAD_BITS-1:0] res_payload;
   logic [63:0] res_epoch, res_ticket;
   logic res_ok;

   always_ff @(posedge clock) begin
      if (reset) cap_ff <= skc_pkg::CAP_RESET;
      else if (csr_we) cap_ff <= csr_wdata;
   end

   skc_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .sts, .ctl
   );

   skc_datapath #(.ENTRIES(ENTRIES), .PAYLOAD_BITS(PAYLOAD_BITS)) u_dp (
      .clock, .reset, .ctl, .sts,
      .in_cmd(req_tdata[2:0]), .in_x(req_tdata[34:3]), .in_y(req_tdata[66:35]),
      .in_z(req_tdata[98:67]), .in_level(req_tdata[100:99]),
      .in_payload(req_tdata[132:101]), .in_ticket(req_tdata[196:133]),
      .in_epoch(req_tdata[260:197]), .capacity(cap_ff),
      .res_payload, .res_epoch, .res_ticket, .res_ok
   );

   assign rsp_tdata = {7'd0, res_ticket, res_epoch, 32'(res_payload), res_ok};
endmodule
`default_nettype wire
